// ===== src/lrupr_pkg.sv =====
package lrupr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 20;

  // fixed field widths on the ports
  localparam int PAGE_FIELD_W  = 20;
  localparam int INDEX_FIELD_W = 4;
  localparam int COUNT_W       = 32;
  localparam int FC_W          = 5;
  localparam int S_TDATA_W     = 24;
  localparam int M_TDATA_W     = 64;

  localparam logic [FC_W-1:0] FC_RESET = 5'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_HIT,
    CMD_FILL,
    CMD_EVICT
  } cmd_kind_t;

  typedef struct packed {
    logic valid;
    logic found;
  } scan_flags_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      clear;
  } cmd_t;

endpackage

// ===== src/lrupr_cell.sv =====
module lrupr_cell #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [$clog2(MAX_FRAMES+1)-1:0] n,
  // scan record from the previous cell
  input  lrupr_pkg::scan_flags_t  flags_in,
  input  logic [PAGE_BITS-1:0]    page_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] fidx_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] frank_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] bidx_in,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] brank_in,
  input  logic [PAGE_BITS-1:0]    bpage_in,
  // scan record to the next cell
  output lrupr_pkg::scan_flags_t  flags_out,
  output logic [PAGE_BITS-1:0]    page_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] fidx_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] frank_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] bidx_out,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] brank_out,
  output logic [PAGE_BITS-1:0]    bpage_out,
  // update broadcast to all cells
  input  lrupr_pkg::cmd_t         cmd,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] cmd_slot,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] cmd_rank,
  input  logic [PAGE_BITS-1:0]    cmd_page
);

  localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam logic [SW-1:0] MY_IDX = SW'(IDX);
  localparam logic [NW-1:0] MY_POS = NW'(IDX);

  logic [PAGE_BITS-1:0] frame_page;
  logic [PAGE_BITS-1:0] frame_page_next;
  logic                 frame_valid;
  logic                 frame_valid_next;
  logic [SW-1:0]        recency_rank;
  logic [SW-1:0]        recency_rank_next;

  logic                 eligible;
  logic                 match;
  logic                 older;
  logic                 is_slot;
  logic [PAGE_BITS-1:0] base_bpage;

  // frames at or above the usable count are skipped by lookup and victim search
  assign eligible   = (MY_POS < n) && frame_valid;
  assign match      = flags_in.valid && eligible && !flags_in.found && (frame_page == page_in);
  assign older      = eligible && (recency_rank > brank_in);
  // frame 0 is the victim when no rank beats zero
  assign base_bpage = (IDX == 0) ? frame_page : bpage_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out.valid <= 1'b0;
      flags_out.found <= 1'b0;
    end else begin
      flags_out.valid <= flags_in.valid;
      flags_out.found <= flags_in.found | match;
    end
  end

  always_ff @(posedge clk) begin
    page_out  <= page_in;
    fidx_out  <= match ? MY_IDX : fidx_in;
    frank_out <= match ? recency_rank : frank_in;
    bidx_out  <= older ? MY_IDX : bidx_in;
    brank_out <= older ? recency_rank : brank_in;
    bpage_out <= older ? frame_page : base_bpage;
  end

  assign is_slot = (cmd_slot == MY_IDX);

  always_comb begin
    frame_valid_next  = frame_valid;
    recency_rank_next = recency_rank;
    frame_page_next   = frame_page;
    case (cmd.kind)
      lrupr_pkg::CMD_HIT, lrupr_pkg::CMD_EVICT: begin
        if (is_slot) begin
          recency_rank_next = '0;
          if (cmd.kind == lrupr_pkg::CMD_EVICT) begin
            frame_page_next = cmd_page;
          end
        end else if (frame_valid && (recency_rank < cmd_rank)) begin
          recency_rank_next = recency_rank + SW'(1);
        end
      end
      lrupr_pkg::CMD_FILL: begin
        if (is_slot) begin
          frame_valid_next  = 1'b1;
          recency_rank_next = '0;
          frame_page_next   = cmd_page;
        end else if (frame_valid) begin
          recency_rank_next = recency_rank + SW'(1);
        end
      end
      default: begin
      end
    endcase
    // end of string empties the frame after its own update
    if ((cmd.kind != lrupr_pkg::CMD_NONE) && cmd.clear) begin
      frame_valid_next  = 1'b0;
      recency_rank_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid  <= 1'b0;
      recency_rank <= '0;
    end else begin
      frame_valid  <= frame_valid_next;
      recency_rank <= recency_rank_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_page <= frame_page_next;
  end

endmodule

// ===== src/lru_page_replacement.sv =====
// LRU page replacement over a row of page frames.
// Input items arrive on s_tvalid/s_tready with the page number in s_tdata and
// s_tlast marking the last reference of a string. Each item gives exactly one
// result on m_tvalid/m_tready: fault flag, frame index, evicted flag and page,
// and the saturating fault count of the string; m_tlast echoes s_tlast.
// The usable frame count is written on cfg_valid/cfg_ready/cfg_data
// (always ready); the user must write it only while no item is in flight,
// which the block does not enforce. 0 acts as 1, large values as MAX_FRAMES.
// An item walks the frame row one frame per cycle, then the row updates in
// one broadcast, in which the result is loaded into the output register.
// One item is in flight at a time, so the block takes no new item until
// the previous one has made its row update.
// The output register holds a finished result while the receiver stalls; the
// update of the row waits until that register is free.
// Synchronous reset empties all frames, clears the fault count and sets the
// frame count to 4. A result with m_tlast set also empties the frames and
// clears the count once it is produced.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrupr_pkg::FC_W-1:0]        cfg_data,      // frame_count
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lrupr_pkg::S_TDATA_W-1:0]   s_tdata,       // [19:0] page_number
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] was_fault, [4:1] frame_index, [5] evicted_valid, [25:6] evicted_page,
  // [57:26] fault_total
  output logic [lrupr_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast
);

  localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int CW = lrupr_pkg::COUNT_W;
  localparam int M_USED = 1 + lrupr_pkg::INDEX_FIELD_W + 1 + lrupr_pkg::PAGE_FIELD_W + CW;
  localparam int OUT_FAULT_BIT = 0;
  localparam int OUT_EVV_BIT   = 1 + lrupr_pkg::INDEX_FIELD_W;

  logic [lrupr_pkg::FC_W-1:0] frame_count;
  logic [NW-1:0]              n;
  logic [6:0]                 fc_wide;

  lrupr_pkg::state_t state;
  lrupr_pkg::state_t state_next;
  logic              accept;
  logic              pend_load;
  logic              commit_go;
  logic              out_free;

  lrupr_pkg::scan_flags_t ch_flags [0:MAX_FRAMES];
  logic [PAGE_BITS-1:0]   ch_page  [0:MAX_FRAMES];
  logic [SW-1:0]          ch_fidx  [0:MAX_FRAMES];
  logic [SW-1:0]          ch_frank [0:MAX_FRAMES];
  logic [SW-1:0]          ch_bidx  [0:MAX_FRAMES];
  logic [SW-1:0]          ch_brank [0:MAX_FRAMES];
  logic [PAGE_BITS-1:0]   ch_bpage [0:MAX_FRAMES];

  logic                 item_last;
  logic                 pend_found;
  logic [SW-1:0]        pend_fidx;
  logic [SW-1:0]        pend_frank;
  logic [SW-1:0]        pend_bidx;
  logic [SW-1:0]        pend_brank;
  logic [PAGE_BITS-1:0] pend_bpage;
  logic [PAGE_BITS-1:0] pend_page;

  logic [NW-1:0] filled;
  logic [CW-1:0] fault_counter;

  lrupr_pkg::cmd_kind_t kind;
  lrupr_pkg::cmd_t      cmd;
  logic [SW-1:0]        slot;
  logic [SW-1:0]        slot_rank;
  logic                 fault;
  logic                 ev_valid;
  logic [lrupr_pkg::PAGE_FIELD_W-1:0] ev_page;
  logic [CW-1:0]        total_next;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= lrupr_pkg::FC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_count <= cfg_data;
    end
  end

  always_comb begin
    fc_wide = 7'(frame_count);
    if (fc_wide == 7'd0) begin
      n = NW'(1);
    end else if (fc_wide > 7'(MAX_FRAMES)) begin
      n = NW'(MAX_FRAMES);
    end else begin
      n = NW'(fc_wide);
    end
  end

  // control
  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      lrupr_pkg::ST_IDLE:   if (s_tvalid) state_next = lrupr_pkg::ST_SCAN;
      lrupr_pkg::ST_SCAN:   if (ch_flags[MAX_FRAMES].valid) state_next = lrupr_pkg::ST_COMMIT;
      lrupr_pkg::ST_COMMIT: if (out_free) state_next = lrupr_pkg::ST_IDLE;
      default:              state_next = lrupr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    pend_load = 1'b0;
    commit_go = 1'b0;
    case (state)
      lrupr_pkg::ST_IDLE:   s_tready  = 1'b1;
      lrupr_pkg::ST_SCAN:   pend_load = ch_flags[MAX_FRAMES].valid;
      lrupr_pkg::ST_COMMIT: commit_go = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // head of the frame row
  assign ch_flags[0].valid = accept;
  assign ch_flags[0].found = 1'b0;
  assign ch_page[0]        = PAGE_BITS'(s_tdata[lrupr_pkg::PAGE_FIELD_W-1:0]);
  assign ch_fidx[0]        = '0;
  assign ch_frank[0]       = '0;
  assign ch_bidx[0]        = '0;
  assign ch_brank[0]       = '0;
  assign ch_bpage[0]       = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_frame
    lrupr_cell #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .IDX        (i)
    ) u_frame (
      .clk       (clk),
      .rst       (rst),
      .n         (n),
      .flags_in  (ch_flags[i]),
      .page_in   (ch_page[i]),
      .fidx_in   (ch_fidx[i]),
      .frank_in  (ch_frank[i]),
      .bidx_in   (ch_bidx[i]),
      .brank_in  (ch_brank[i]),
      .bpage_in  (ch_bpage[i]),
      .flags_out (ch_flags[i+1]),
      .page_out  (ch_page[i+1]),
      .fidx_out  (ch_fidx[i+1]),
      .frank_out (ch_frank[i+1]),
      .bidx_out  (ch_bidx[i+1]),
      .brank_out (ch_brank[i+1]),
      .bpage_out (ch_bpage[i+1]),
      .cmd       (cmd),
      .cmd_slot  (slot),
      .cmd_rank  (slot_rank),
      .cmd_page  (pend_page)
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_last <= s_tlast;
    end
    if (pend_load) begin
      pend_found <= ch_flags[MAX_FRAMES].found;
      pend_fidx  <= ch_fidx[MAX_FRAMES];
      pend_frank <= ch_frank[MAX_FRAMES];
      pend_bidx  <= ch_bidx[MAX_FRAMES];
      pend_brank <= ch_brank[MAX_FRAMES];
      pend_bpage <= ch_bpage[MAX_FRAMES];
      pend_page  <= ch_page[MAX_FRAMES];
    end
  end

  // decision for the item at the tail of the row
  always_comb begin
    kind      = lrupr_pkg::CMD_EVICT;
    slot      = pend_bidx;
    slot_rank = pend_brank;
    fault     = 1'b1;
    ev_valid  = 1'b0;
    if (pend_found) begin
      kind      = lrupr_pkg::CMD_HIT;
      slot      = pend_fidx;
      slot_rank = pend_frank;
      fault     = 1'b0;
    end else if (filled < n) begin
      kind      = lrupr_pkg::CMD_FILL;
      slot      = SW'(filled);
      slot_rank = '0;
    end else begin
      ev_valid  = 1'b1;
    end
    ev_page    = ev_valid ? lrupr_pkg::PAGE_FIELD_W'(pend_bpage) : '0;
    total_next = fault_counter;
    if (fault && (fault_counter != '1)) begin
      total_next = fault_counter + CW'(1);
    end
    cmd.kind  = commit_go ? kind : lrupr_pkg::CMD_NONE;
    cmd.clear = item_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled        <= '0;
      fault_counter <= '0;
    end else if (commit_go) begin
      if (item_last) begin
        filled        <= '0;
        fault_counter <= '0;
      end else begin
        if (kind == lrupr_pkg::CMD_FILL) begin
          filled <= filled + NW'(1);
        end
        fault_counter <= total_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      m_tdata <= {{(lrupr_pkg::M_TDATA_W - M_USED){1'b0}}, total_next, ev_page, ev_valid,
                  lrupr_pkg::INDEX_FIELD_W'(slot), fault};
      m_tlast <= item_last;
    end
  end

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= NW'(MAX_FRAMES))
    else $error("filled frame count above capacity");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit_go |=> m_tvalid)
    else $error("row update without a result");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    ch_flags[MAX_FRAMES].valid |-> (state == lrupr_pkg::ST_SCAN))
    else $error("scan record at the tail outside of a scan");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (commit_go && item_last) |=> ((filled == '0) && (fault_counter == '0)))
    else $error("end of string did not clear the frames");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_EVV_BIT]) |-> m_tdata[OUT_FAULT_BIT])
    else $error("eviction reported on a hit");

endmodule

// ===== dv/lru_page_replacement_tb.sv =====
`timescale 1ns / 100ps

module lru_page_replacement_tb;

  localparam int FRAMES  = lrupr_pkg::MAX_FRAMES_DEF;
  localparam int LATENCY = FRAMES + 2;
  localparam int IW      = lrupr_pkg::INDEX_FIELD_W;
  localparam int PW      = lrupr_pkg::PAGE_FIELD_W;
  localparam int CNTW    = lrupr_pkg::COUNT_W;
  localparam int FCW     = lrupr_pkg::FC_W;
  localparam int SDW     = lrupr_pkg::S_TDATA_W;
  localparam int MDW     = lrupr_pkg::M_TDATA_W;

  typedef struct packed {
    logic            was_fault;
    logic [IW-1:0]   frame_index;
    logic            evicted_valid;
    logic [PW-1:0]   evicted_page;
    logic [CNTW-1:0] fault_total;
    logic            end_of_string;
  } page_outcome_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [FCW-1:0] cfg_data  = '0;
  logic           s_tvalid  = 1'b0;
  logic           s_tready;
  logic [SDW-1:0] s_tdata   = '0;
  logic           s_tlast   = 1'b0;
  logic           m_tvalid;
  logic           m_tready  = 1'b0;
  logic [MDW-1:0] m_tdata;
  logic           m_tlast;

  lru_page_replacement i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the frame table
  logic [PW-1:0]   resident_page [FRAMES];
  bit              occupied [FRAMES];
  int unsigned     age [FRAMES];
  int unsigned     filled;
  logic [CNTW-1:0] faults_in_string;
  logic [FCW-1:0]  frame_count;

  page_outcome_t expected_outcomes[$];

  int send_idle_pct  = 0;
  int ready_idle_pct = 0;
  int mismatches     = 0;
  int n_refs         = 0;
  int n_faults       = 0;
  int n_evictions    = 0;
  int n_strings      = 0;
  int n_writes       = 0;

  function automatic void clear_string();
    for (int k = 0; k < FRAMES; k++) begin
      occupied[k] = 1'b0;
      age[k]      = 0;
    end
    filled           = 0;
    faults_in_string = '0;
  endfunction

  // frame f becomes most recent, everything younger ages by one
  function automatic void refresh_frame(int unsigned f);
    for (int k = 0; k < FRAMES; k++) begin
      if (occupied[k] && k != f && age[k] < age[f]) age[k] = age[k] + 1;
    end
    age[f] = 0;
  endfunction

  function automatic page_outcome_t lookup_page(logic [PW-1:0] page, bit last);
    int unsigned   n;
    int unsigned   slot;
    int unsigned   oldest;
    bit            hit;
    page_outcome_t r;
    r    = '0;
    hit  = 1'b0;
    slot = 0;
    if (frame_count == 0) n = 1;
    else if (frame_count > FRAMES) n = FRAMES;
    else n = frame_count;
    for (int k = 0; k < n; k++) begin
      if (!hit && occupied[k] && resident_page[k] == page) begin
        hit  = 1'b1;
        slot = k;
      end
    end
    if (hit) begin
      refresh_frame(slot);
    end else begin
      if (filled < n) begin
        slot = filled;
        for (int k = 0; k < FRAMES; k++) begin
          if (occupied[k]) age[k] = age[k] + 1;
        end
        occupied[slot] = 1'b1;
        age[slot]      = 0;
        filled         = filled + 1;
      end else begin
        // only frames below the count can be victims
        oldest = 0;
        slot   = 0;
        for (int k = 0; k < n; k++) begin
          if (occupied[k] && age[k] > oldest) begin
            oldest = age[k];
            slot   = k;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = resident_page[slot];
        refresh_frame(slot);
      end
      resident_page[slot] = page;
      if (faults_in_string != '1) faults_in_string = faults_in_string + 1;
    end
    r.was_fault     = !hit;
    r.frame_index   = slot[IW-1:0];
    r.fault_total   = faults_in_string;
    r.end_of_string = last;
    if (last) clear_string();
    return r;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= ready_idle_pct);
  end

  always @(posedge clk) begin
    page_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no reference outstanding: tdata 0x%0h", m_tdata);
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("was_fault", want.was_fault, m_tdata[0]);
        compare_field("frame_index", want.frame_index, m_tdata[4:1]);
        compare_field("evicted_valid", want.evicted_valid, m_tdata[5]);
        compare_field("evicted_page", want.evicted_page, m_tdata[25:6]);
        compare_field("fault_total", want.fault_total, m_tdata[57:26]);
        compare_field("end_of_string", want.end_of_string, m_tlast);
      end
    end
  end

  task automatic send_reference(input logic [PW-1:0] page, input bit last);
    page_outcome_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(SDW-PW){1'b0}}, page};
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    r = lookup_page(page, last);
    expected_outcomes.push_back(r);
    n_refs++;
    n_faults    += r.was_fault;
    n_evictions += r.evicted_valid;
    n_strings   += last;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic set_frame_count(input logic [FCW-1:0] value);
    wait_for_drain();
    repeat (2) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    frame_count = value;
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [FCW-1:0] pick_frame_count();
    case ($urandom_range(5))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(2, 15));
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    ready_idle_pct = 0;
    // default of four frames: fill, hit, evictions, end of string
    send_reference(20'h00000, 1'b0);
    send_reference(20'hFFFFF, 1'b0);
    send_reference(20'h00000, 1'b0);
    send_reference(20'h00001, 1'b0);
    send_reference(20'h00002, 1'b0);
    send_reference(20'h00003, 1'b0);
    send_reference(20'h00000, 1'b0);
    send_reference(20'h00004, 1'b0);
    send_reference(20'h00002, 1'b1);
    // zero acts as a single frame
    set_frame_count(5'd0);
    send_reference(20'h00005, 1'b0);
    send_reference(20'h00005, 1'b0);
    send_reference(20'h00006, 1'b0);
    // raised mid-string, value above the frame capacity
    set_frame_count(5'd31);
    send_reference(20'h00007, 1'b0);
    send_reference(20'h00006, 1'b0);
    send_reference(20'h00008, 1'b0);
    // lowered mid-string: frame 2 is hidden, victims come from below the count
    set_frame_count(5'd2);
    send_reference(20'h00009, 1'b0);
    send_reference(20'h00008, 1'b1);
  endtask

  task automatic test_random_strings(input int send_pct, input int ready_pct,
                                     input int n_items);
    logic [PW-1:0] pool [32];
    int unsigned   pool_size;
    logic [PW-1:0] page;
    bit            last;
    send_idle_pct  = send_pct;
    ready_idle_pct = ready_pct;
    pool_size      = 0;
    for (int i = 0; i < n_items; i++) begin
      if (pool_size == 0) begin
        // working set of 2 to 24 pages, larger or smaller than the frame count
        pool_size = $urandom_range(2, 24);
        for (int j = 0; j < pool_size; j++) begin
          pool[j] = ($urandom_range(3) == 0) ? 20'($urandom_range(63)) : 20'($urandom);
        end
      end
      if ($urandom_range(119) == 0) set_frame_count(pick_frame_count());
      if (i % 150 == 149) wait_for_drain();
      page = ($urandom_range(9) == 0) ? 20'($urandom) : pool[$urandom_range(pool_size - 1)];
      last = ($urandom_range(39) == 0);
      send_reference(page, last);
      if (last) pool_size = 0;
    end
  endtask

  initial begin
    clear_string();
    for (int k = 0; k < FRAMES; k++) resident_page[k] = '0;
    frame_count = lrupr_pkg::FC_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    set_frame_count(5'd16);
    test_random_strings(11, 56, 650);
    set_frame_count(5'd1);
    test_random_strings(56, 11, 650);
    set_frame_count(5'd4);
    test_random_strings(0, 0, 650);

    wait_for_drain();
    repeat (LATENCY + 4) @(posedge clk);
    $display("covered %0d references in %0d strings: %0d faults, %0d evictions",
             n_refs, n_strings, n_faults, n_evictions);
    $display("frame count rewritten %0d times, %0d mismatches", n_writes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lru_page_replacement.sv
dv/lru_page_replacement_tb.sv
